[rtl/core/capture_file_record_deframer_unit_assert.svh]
// Assertion macros shared by the capture file record deframer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CAPTURE_FILE_RECORD_DEFRAMER_UNIT_ASSERT_SVH
`define CAPTURE_FILE_RECORD_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CFRD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cfrd_pkg.sv]
// Package of the capture file record deframer: types, constants and helpers.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cfrd_pkg;

    localparam logic [31:0] MAGIC_USEC    = 32'ha1b2c3d4;
    localparam logic [31:0] MAGIC_NSEC    = 32'ha1b23c4d;
    localparam logic [31:0] MAGIC_SWAPPED = 32'hd4c3b2a1;
    localparam logic [15:0] LENGTH_LIMIT  = 16'hffff;
    localparam logic [15:0] SKIP_BYTES    = 16'd20;
    localparam logic [15:0] WORD_BYTES    = 16'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_SKIP    = 3'd1,
        PH_SEC     = 3'd2,
        PH_FRAC    = 3'd3,
        PH_CAPLEN  = 3'd4,
        PH_ORIG    = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_HALT    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] seconds;
        logic [31:0] fraction;
        logic [15:0] length;
        logic [7:0]  data;
        logic        last;
    } result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic logic [31:0] shift_in(input logic [31:0] word, input logic [7:0] b,
                                             input logic big);
        logic [31:0] res;
        if (big)
        begin
            res = {word[23:0], b};
        end
        else
        begin
            res = {b, word[31:8]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cfrd_front.sv]
// Front end of the capture file record deframer: accepts bytes and parses them.
// Depends on cfrd_pkg; pushes result words into cfrd_queue.
`timescale 1ns / 1ps
`default_nettype none

module cfrd_front
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [15:0]            cfg_wr_data,
    input  wire logic                   byte_valid,
    output logic                        byte_ready,
    input  wire logic [7:0]             in_byte,
    input  wire cfrd_pkg::queue_status_t q_status,
    output logic                        push,
    output cfrd_pkg::result_t           push_data
);

    cfrd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic        swap_reg, swap_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] sec_reg, sec_next;
    logic [31:0] frac_reg, frac_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] max_len_reg;
    logic        accept;
    logic [15:0] count_inc;

    assign byte_ready = !q_status.full;
    assign accept     = byte_valid && byte_ready;
    assign count_inc  = count_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= cfrd_pkg::PH_MAGIC;
            count_reg   <= '0;
            swap_reg    <= 1'b0;
            magic_reg   <= '0;
            shift_reg   <= '0;
            sec_reg     <= '0;
            frac_reg    <= '0;
            len_reg     <= '0;
            max_len_reg <= cfrd_pkg::LENGTH_LIMIT;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            swap_reg  <= swap_next;
            magic_reg <= magic_next;
            shift_reg <= shift_next;
            sec_reg   <= sec_next;
            frac_reg  <= frac_next;
            len_reg   <= len_next;
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        swap_next  = swap_reg;
        magic_next = magic_reg;
        shift_next = shift_reg;
        sec_next   = sec_reg;
        frac_next  = frac_reg;
        len_next   = len_reg;
        push       = 1'b0;
        push_data.kind     = cfrd_pkg::KIND_HEADER;
        push_data.seconds  = sec_reg;
        push_data.fraction = frac_reg;
        push_data.length   = len_reg;
        push_data.data     = 8'd0;
        push_data.last     = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                cfrd_pkg::PH_MAGIC:
                begin
                    magic_next = cfrd_pkg::shift_in(magic_reg, in_byte, 1'b0);
                    count_next = count_inc;
                    if (count_inc == cfrd_pkg::WORD_BYTES)
                    begin
                        swap_next  = !(magic_next == cfrd_pkg::MAGIC_USEC ||
                                       magic_next == cfrd_pkg::MAGIC_NSEC);
                        count_next = '0;
                        phase_next = cfrd_pkg::PH_SKIP;
                    end
                end
                cfrd_pkg::PH_SKIP:
                begin
                    count_next = count_inc;
                    if (count_inc >= cfrd_pkg::SKIP_BYTES)
                    begin
                        count_next = '0;
                        phase_next = cfrd_pkg::PH_SEC;
                    end
                end
                cfrd_pkg::PH_SEC, cfrd_pkg::PH_FRAC, cfrd_pkg::PH_CAPLEN:
                begin
                    shift_next = cfrd_pkg::shift_in(shift_reg, in_byte, swap_reg);
                    count_next = count_inc;
                    if (count_inc == cfrd_pkg::WORD_BYTES)
                    begin
                        count_next = '0;
                        if (phase_reg == cfrd_pkg::PH_SEC)
                        begin
                            sec_next   = shift_next;
                            phase_next = cfrd_pkg::PH_FRAC;
                        end
                        else if (phase_reg == cfrd_pkg::PH_FRAC)
                        begin
                            frac_next  = shift_next;
                            phase_next = cfrd_pkg::PH_CAPLEN;
                        end
                        else
                        begin
                            phase_next = cfrd_pkg::PH_ORIG;
                        end
                    end
                end
                cfrd_pkg::PH_ORIG:
                begin
                    count_next = count_inc;
                    if (count_inc == cfrd_pkg::WORD_BYTES)
                    begin
                        count_next = '0;
                        push       = 1'b1;
                        if (shift_reg > {16'd0, max_len_reg})
                        begin
                            push_data.kind   = cfrd_pkg::KIND_ERROR;
                            push_data.length = (shift_reg[31:16] != 16'd0) ?
                                               cfrd_pkg::LENGTH_LIMIT : shift_reg[15:0];
                            phase_next       = cfrd_pkg::PH_HALT;
                        end
                        else
                        begin
                            len_next         = shift_reg[15:0];
                            shift_next       = '0;
                            push_data.length = shift_reg[15:0];
                            push_data.last   = (shift_reg[15:0] == 16'd0);
                            phase_next       = (shift_reg[15:0] == 16'd0) ?
                                               cfrd_pkg::PH_SEC : cfrd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                cfrd_pkg::PH_PAYLOAD:
                begin
                    push           = 1'b1;
                    push_data.kind = cfrd_pkg::KIND_PAYLOAD;
                    push_data.data = in_byte;
                    count_next     = count_inc;
                    if (count_inc >= len_reg)
                    begin
                        push_data.last = 1'b1;
                        count_next     = '0;
                        phase_next     = cfrd_pkg::PH_SEC;
                    end
                end
                cfrd_pkg::PH_HALT:
                begin
                    phase_next = cfrd_pkg::PH_HALT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/cfrd_queue.sv]
// Short result queue between the parsing front end and the output back end.
// Depends on cfrd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "capture_file_record_deframer_unit_assert.svh"

module cfrd_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cfrd_pkg::result_t push_data,
    input  wire logic              pop,
    output cfrd_pkg::result_t      head_data,
    output cfrd_pkg::queue_status_t status
);

    cfrd_pkg::result_t entry_reg [cfrd_pkg::QUEUE_DEPTH];
    logic [cfrd_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cfrd_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (cfrd_pkg::QUEUE_AW + 1)'(cfrd_pkg::QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `CFRD_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, status.full, !push, "push into full queue")
    `CFRD_ASSERT_IMPL(a_no_pop_when_empty, clk, rst_n, status.empty, !pop, "pop from empty queue")
    `CFRD_ASSERT_NEXT(a_count_up, clk, rst_n, do_push && !do_pop,
                      count_reg == $past(count_reg) + 1'b1, "queue count did not rise")

endmodule

`default_nettype wire

[rtl/core/cfrd_back.sv]
// Back end of the capture file record deframer: output register and handshake.
// Depends on cfrd_pkg; takes result words from cfrd_queue.
`timescale 1ns / 1ps
`default_nettype none

module cfrd_back
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cfrd_pkg::queue_status_t q_status,
    input  wire cfrd_pkg::result_t       head_data,
    output logic                         pop,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output cfrd_pkg::result_t            out_data
);

    logic              valid_reg, valid_next;
    cfrd_pkg::result_t data_reg;
    logic              load;

    assign load         = !valid_reg || result_ready;
    assign pop          = load && !q_status.empty;
    assign valid_next   = pop ? 1'b1 : (result_ready ? 1'b0 : valid_reg);
    assign result_valid = valid_reg;
    assign out_data     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/capture_file_record_deframer_unit.sv]
// Top level of the capture file record deframer.
// Depends on cfrd_pkg, cfrd_front, cfrd_queue and cfrd_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one word (a byte of the capture file) per clock cycle while
// the queue is not full and gives at most one result word per cycle. A result
// reaches the outputs through the queue and then the output register: the
// parsing front end writes it into the queue at the edge that takes the byte,
// and the output register picks it up from the queue once the output is free.
// A four-entry queue sits between the two, so the input keeps flowing while
// the output stalls until the queue fills. After an invalid length the block
// keeps taking input but gives no further results until reset.

module capture_file_record_deframer_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  in_byte,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       result_kind,
    output logic [31:0]      ts_seconds,
    output logic [31:0]      ts_fraction,
    output logic [15:0]      capture_length,
    output logic [7:0]       payload_byte,
    output logic             last_byte
);

    cfrd_pkg::queue_status_t q_status;
    cfrd_pkg::result_t       push_data, head_data, out_data;
    logic                    push, pop;

    cfrd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .in_byte     (in_byte),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    cfrd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    cfrd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_data    (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_data     (out_data)
    );

    assign result_kind    = out_data.kind;
    assign ts_seconds     = out_data.seconds;
    assign ts_fraction    = out_data.fraction;
    assign capture_length = out_data.length;
    assign payload_byte   = out_data.data;
    assign last_byte      = out_data.last;

endmodule

`default_nettype wire
